[sv/i2a_pkg.sv]
// Package for the integer to decimal text converter.
// Holds the character codes, the power-of-ten table and the classification type.
// No dependencies; every other file of the block but i2a_num_if uses it.
package i2a_pkg;

	localparam int CODE_W    = 6;
	localparam int POS_W     = 5;
	localparam int NUM_POW   = 20;
	localparam int PROD_W    = 68;
	localparam int MAX_DIGIT = 9;

	localparam logic [CODE_W-1:0] CH_MINUS = 6'd45;
	localparam logic [CODE_W-1:0] CH_ZERO  = 6'd48;

	// Sign and index of the leading decimal position of one queued number.
	typedef struct packed {
		logic             neg;
		logic [POS_W-1:0] top;
	} i2a_cls_t;

	function automatic logic [63:0] pow10(input logic [POS_W-1:0] k);
		logic [63:0] p;
		case (k)
			5'd0:    p = 64'd1;
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			5'd16:   p = 64'd10000000000000000;
			5'd17:   p = 64'd100000000000000000;
			5'd18:   p = 64'd1000000000000000000;
			5'd19:   p = 64'd10000000000000000000;
			default: p = 64'd0;
		endcase
		return p;
	endfunction

endpackage

[sv/i2a_num_if.sv]
// Input channel of the converter: one signed integer per beat.
// Standalone interface with valid/ready handshake; no dependencies.
interface i2a_num_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[sv/i2a_text_if.sv]
// Output channel of the converter: one ASCII character per beat.
// Uses the character code width from i2a_pkg.
interface i2a_text_if;
	logic                        valid;
	logic                        ready;
	logic [i2a_pkg::CODE_W-1:0]  char_code;
	logic                        last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

[sv/int32_to_decimal_ascii_core.sv]
// Top level of the signed integer to decimal ASCII converter.
// Depends on i2a_pkg, i2a_num_if, i2a_text_if, i2a_front, i2a_queue and i2a_back.
//
//   Channel   Direction   Beat contents
//   num       in          value: signed integer, VALUE_WIDTH bits
//   text      out         char_code: ASCII '-' or '0'..'9'; last: end of the number
//
// An integer is loaded into the digit engine while it is idle; the engine then emits one
// character per cycle unless text.ready stalls it, and takes no new integer before the last digit.
// The front end classifies a beat in the cycle it is accepted and a two-entry queue
// buffers work, so num stays ready until the queue is full.
// Reset clears all control state at once; there is no clearing pass.
// A low text.ready while text.valid is high holds the output register and stalls the digit loop.
module int32_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	i2a_num_if.sink    num,
	i2a_text_if.source text
);
	import i2a_pkg::*;

	logic                   push;
	logic [VALUE_WIDTH-1:0] push_mag;
	i2a_cls_t               push_cls;
	logic                   q_full;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [VALUE_WIDTH-1:0] pop_mag;
	i2a_cls_t               pop_cls;

	i2a_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.num      (num),
		.q_full   (q_full),
		.push     (push),
		.push_mag (push_mag),
		.push_cls (push_cls)
	);

	i2a_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_mag  (push_mag),
		.push_cls  (push_cls),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_mag   (pop_mag),
		.pop_cls   (pop_cls)
	);

	i2a_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_mag   (pop_mag),
		.pop_cls   (pop_cls),
		.text      (text)
	);

endmodule

[sv/i2a_front.sv]
// Front end: accepts integers, takes sign and magnitude and finds the digit count.
// Depends on i2a_pkg and i2a_num_if; feeds i2a_queue.
module i2a_front #(
	parameter int VALUE_WIDTH = 32
) (
	i2a_num_if.sink                num,
	input  logic                   q_full,
	output logic                   push,
	output logic [VALUE_WIDTH-1:0] push_mag,
	output i2a_pkg::i2a_cls_t      push_cls
);
	import i2a_pkg::*;

	logic [VALUE_WIDTH-1:0] raw;
	logic                   neg;
	logic [63:0]            mag64;
	logic [POS_W-1:0]       top;

	assign raw = unsigned'(num.value);
	assign neg = raw[VALUE_WIDTH-1];
	// The magnitude of the most negative value still fits as an unsigned word.
	assign push_mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
	assign mag64 = 64'(push_mag);

	// The leading position is the highest power of ten not above the magnitude.
	always_comb begin
		top = '0;
		for (int k = 1; k < NUM_POW; k++) begin
			if (mag64 >= pow10(POS_W'(k))) begin
				top = POS_W'(k);
			end
		end
	end

	assign num.ready    = !q_full;
	assign push         = num.valid && !q_full;
	assign push_cls.neg = neg;
	assign push_cls.top = top;

endmodule

[sv/i2a_queue.sv]
// Two-entry queue between the front end and the digit engine.
// Depends on i2a_pkg for the classification type.
module i2a_queue #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [VALUE_WIDTH-1:0] push_mag,
	input  i2a_pkg::i2a_cls_t      push_cls,
	output logic                   full,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output logic [VALUE_WIDTH-1:0] pop_mag,
	output i2a_pkg::i2a_cls_t      pop_cls
);
	import i2a_pkg::*;

	logic [VALUE_WIDTH-1:0] mag_q [0:1];
	i2a_cls_t               cls_q [0:1];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   pop;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_mag   = mag_q[rd_ptr_q];
	assign pop_cls   = cls_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mag_q[wr_ptr_q] <= push_mag;
			cls_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/i2a_back.sv]
// Digit engine: emits a minus sign for a negative number, then one decimal digit per beat, most significant first.
// Depends on i2a_pkg and i2a_text_if; takes work from i2a_queue.
module i2a_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  logic [VALUE_WIDTH-1:0] pop_mag,
	input  i2a_pkg::i2a_cls_t      pop_cls,
	i2a_text_if.source             text
);
	import i2a_pkg::*;

	logic                   busy_q;
	logic                   sign_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [POS_W-1:0]       pos_q;
	logic                   ov_q;
	logic [CODE_W-1:0]      oc_q;
	logic                   ol_q;

	logic                   adv;
	logic [PROD_W-1:0]      p_w;
	logic [PROD_W-1:0]      rem_w;
	logic [PROD_W-1:0]      mul [0:MAX_DIGIT];
	logic [3:0]             digit;
	logic [VALUE_WIDTH-1:0] rem_nx;

	assign adv       = !ov_q || text.ready;
	assign pop_ready = !busy_q;

	// Each digit is the largest multiple of the current power of ten that still fits.
	always_comb begin
		p_w   = PROD_W'(pow10(pos_q));
		rem_w = PROD_W'(rem_q);
		for (int d = 0; d <= MAX_DIGIT; d++) begin
			mul[d] = p_w * PROD_W'(d);
		end
		digit = '0;
		for (int d = 1; d <= MAX_DIGIT; d++) begin
			if (rem_w >= mul[d]) begin
				digit = 4'(d);
			end
		end
		rem_nx = rem_q - VALUE_WIDTH'(mul[digit]);
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			rem_q  <= pop_mag;
			pos_q  <= pop_cls.top;
		end else if (adv && !sign_q) begin
			rem_q  <= rem_nx;
			pos_q  <= pos_q - POS_W'(1);
		end
		if (busy_q && adv) begin
			if (sign_q) begin
				oc_q <= CH_MINUS;
				ol_q <= 1'b0;
			end else begin
				oc_q <= CH_ZERO + CODE_W'(digit);
				ol_q <= (pos_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= busy_q;
			end
			if (!busy_q) begin
				if (pop_valid) begin
					busy_q <= 1'b1;
					sign_q <= pop_cls.neg;
				end
			end else if (adv) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (pos_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign text.valid     = ov_q;
	assign text.char_code = oc_q;
	assign text.last      = ol_q;

	// The remainder must stay below ten times the current power of ten.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !sign_q |-> rem_w < (mul[MAX_DIGIT] + p_w))
		else $error("remainder exceeds current decimal position");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (oc_q == CH_MINUS) |-> !ol_q)
		else $error("minus sign flagged as last character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (oc_q == CH_MINUS) || ((oc_q >= CH_ZERO) && (oc_q <= CH_ZERO + CODE_W'(9))))
		else $error("character code out of range");

endmodule

[sim/tb_int32_to_decimal_ascii_core.sv]
// Testbench for int32_to_decimal_ascii_core: drives signed integers and checks the text beats.
// A directed table comes first, then random values; rows with no typed text use an in-bench predictor.
// Depends on i2a_pkg, i2a_num_if, i2a_text_if and the converter RTL.
`timescale 1ns / 1ps

module tb_int32_to_decimal_ascii_core;

	import i2a_pkg::*;

	localparam int VALUE_WIDTH  = 32;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [CODE_W-1:0] char_code;
		logic              last;
	} char_beat_t;

	// An empty text means the row is checked against the predictor.
	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		string                  text;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   error_count;
	int   cycle_count;

	char_beat_t pending_chars[$];

	i2a_num_if #(.VALUE_WIDTH(VALUE_WIDTH)) num_ch();
	i2a_text_if                             text_ch();

	int32_to_decimal_ascii_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.num   (num_ch.sink),
		.text  (text_ch.source)
	);

	stim_row_t directed_rows [] = '{
		'{32'd0,           "0"},
		'{32'd1,           "1"},
		'{32'hFFFFFFFF,    "-1"},
		'{32'd9,           "9"},
		'{-32'sd9,         "-9"},
		'{32'd10,          "10"},
		'{-32'sd10,        "-10"},
		'{32'h7FFFFFFF,    "2147483647"},
		'{32'h80000000,    "-2147483648"},
		'{32'h80000001,    "-2147483647"},
		'{32'd1000000000,  "1000000000"},
		'{-32'sd1000000000, "-1000000000"},
		'{32'd999999999,   "999999999"},
		'{32'd0,           "0"},
		'{32'h55555555,    ""},
		'{32'hAAAAAAAA,    ""},
		'{32'd12345678,    ""},
		'{-32'sd87654321,  ""},
		'{32'h0000FFFF,    ""},
		'{32'hFFFF0000,    ""},
		'{32'd100,         ""},
		'{-32'sd99,        ""}
	};

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Expected text of one value: the magnitude is kept one bit wider so the most
	// negative value converts exactly.
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
		logic             neg;
		logic [VALUE_WIDTH:0] mag;
		logic [3:0]       digits [0:23];
		int               ndig;
		char_beat_t       beat;
		neg = value[VALUE_WIDTH-1];
		mag = {1'b0, value};
		if (neg)
			mag = (~{1'b1, value}) + 1'b1;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0);
		if (neg) begin
			beat.char_code = CH_MINUS;
			beat.last      = 1'b0;
			pending_chars.push_back(beat);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			beat.char_code = CH_ZERO + CODE_W'(digits[k]);
			beat.last      = (k == 0);
			pending_chars.push_back(beat);
		end
	endfunction

	// Drives one value after a random gap (none while no_idle is set) and records its text once the beat is taken.
	task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input string typed_text);
		int         gap;
		char_beat_t beat;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			num_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_ch.valid <= 1'b1;
		num_ch.value <= value;
		do @(posedge clk); while (!num_ch.ready);
		if (typed_text.len() == 0) begin
			predict_text(value);
		end else begin
			for (int i = 0; i < typed_text.len(); i++) begin
				beat.char_code = CODE_W'(typed_text[i]);
				beat.last      = (i == typed_text.len() - 1);
				pending_chars.push_back(beat);
			end
		end
	endtask

	task automatic wait_text_drained();
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	// Output side: random stalls (none while no_idle is set), then compare each beat with the oldest expectation.
	initial begin
		int         stall;
		char_beat_t want;
		text_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				text_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_ch.ready <= 1'b1;
			do @(posedge clk); while (text_ch.valid !== 1'b1);
			if (pending_chars.size() == 0) begin
				$error("unexpected beat: char_code %0d, last %0b", text_ch.char_code, text_ch.last);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (text_ch.char_code !== want.char_code) begin
					$error("char_code mismatch: expected %0d, actual %0d",
					       want.char_code, text_ch.char_code);
					error_count++;
				end
				if (text_ch.last !== want.last) begin
					$error("last mismatch: expected %0b, actual %0b", want.last, text_ch.last);
					error_count++;
				end
			end
		end
	end

	initial begin
		logic [VALUE_WIDTH-1:0] value;
		longint                 mag;
		longint                 span;
		int                     k;
		int                     offset;
		error_count  = 0;
		cycle_count  = 0;
		no_idle      = 1'b0;
		arst_n       <= 1'b0;
		num_ch.valid <= 1'b0;
		num_ch.value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_value(directed_rows[i].value, directed_rows[i].text);

		// Hold off the sender until every character of the table has come out.
		num_ch.valid <= 1'b0;
		wait_text_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 32 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: value = $urandom;
				1, 2: begin
					// Bounded digit count, so short texts are as common as long ones.
					k = $urandom_range(1, 9);
					span = 1;
					repeat (k) span = span * 10;
					mag = longint'($urandom) % span;
					value = $urandom_range(0, 1) ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
				end
				default: begin
					// Near a power of ten or the ends of the range.
					offset = $urandom_range(0, 4) - 2;
					k = $urandom_range(0, 9);
					span = 1;
					repeat (k) span = span * 10;
					mag = span + offset;
					value = $urandom_range(0, 1) ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
					if ($urandom_range(0, 3) == 0)
						value = 32'h7FFFFFFF - VALUE_WIDTH'($urandom_range(0, 3));
					else if ($urandom_range(0, 3) == 0)
						value = 32'h80000000 + VALUE_WIDTH'($urandom_range(0, 3));
				end
			endcase
			send_value(value, "");
			if (n == RANDOM_ITEMS / 2) begin
				num_ch.valid <= 1'b0;
				wait_text_drained();
			end
		end

		num_ch.valid <= 1'b0;
		wait_text_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
